// File: hw/rtl/scrolling_tilemap_pixel_generator_macros.svh
// Assertion macros shared by the scrolling tilemap pixel generator RTL.
`ifndef SCROLLING_TILEMAP_PIXEL_GENERATOR_MACROS_SVH
`define SCROLLING_TILEMAP_PIXEL_GENERATOR_MACROS_SVH

// Same-cycle implication, reset masked.
`define STPG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, reset masked.
`define STPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/stpg_pkg.sv
// Types, constants and helper functions for the scrolling tilemap pixel generator.
package stpg_pkg;

   localparam int TILE_COUNT      = 8192;
   localparam int PALETTE_ENTRIES = 1024;
   localparam int SCREEN_WIDTH    = 320;
   localparam int SCREEN_HEIGHT   = 224;

   localparam int TILE_DEPTH    = 32768;
   localparam int PATTERN_DEPTH = TILE_COUNT * 8;

   localparam int TILE_AW = $clog2(TILE_DEPTH);
   localparam int PAT_AW  = $clog2(PATTERN_DEPTH);
   localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);

   localparam int TILE_WIDTH = 16;
   localparam int PAT_WIDTH  = 24;
   localparam int PAL_WIDTH  = 16;

   localparam int EXPAND_DIVISOR = 31;

   localparam int CSR_IDX_WIDTH  = 8;
   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PAGE_SELECT = 8'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SCROLL_X    = 8'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SCROLL_Y    = 8'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_OPAQUE_MODE = 8'd3;

   typedef enum logic [1:0] {
      CMD_RENDER  = 2'd0,
      CMD_TILE    = 2'd1,
      CMD_PATTERN = 2'd2,
      CMD_PALETTE = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type      command;
      logic [8:0]   screen_x;
      logic [7:0]   screen_y;
      logic [15:0]  address;
      logic [23:0]  write_data;
   } req_type;

   typedef struct packed {
      logic        drawn;
      logic [2:0]  pen;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } rsp_type;

   // 32-entry expansion table, eight bits per entry, built from constants
   function automatic logic [255:0] expand5_table();
      logic [255:0] t;
      t = '0;
      for (int i = 0; i < 32; i++) begin
         t[i*8 +: 8] = 8'((i * 255 + 15) / EXPAND_DIVISOR);
      end
      return t;
   endfunction

   localparam logic [255:0] EXPAND5_LUT = expand5_table();

   // 5-bit to 8-bit channel expansion, rounds to nearest
   function automatic logic [7:0] expand5(input logic [4:0] v5);
      return EXPAND5_LUT[{v5, 3'b000} +: 8];
   endfunction

endpackage

// File: hw/rtl/scrolling_tilemap_pixel_generator.sv
// Scrolled, paged tilemap layer, 3 bits per pixel. Each request is either a
// render of one screen pixel or a write into the tile, pattern or palette RAM.
// A render adds scroll_x/scroll_y to the screen position, picks a page from the
// page_select nibble of the virtual quadrant, reads the tile word, then the
// pattern row, then the palette word, and returns drawn/pen/RGB888. Off-screen
// renders and writes return nothing. The pipeline is four stages (tile read,
// pattern read, palette read, output register); a render passes through each in
// turn, and one request is taken every cycle while req_stall is low; the rate is
// set by the single port of each RAM, which serves one access a cycle.
// Each write is carried down the pipe and performed at the stage where that RAM
// is read, so reads and writes of every RAM stay in request order. Stages only
// hold when the stage ahead is full and holding, so bubbles are squeezed out and
// req_stall rises only with the whole pipe full and rsp_stall high.
// Configuration writes (csr_*) are always ready and are meant to be issued only
// while the block is idle. No clearing pass: RAM contents are undefined until
// written.
`include "scrolling_tilemap_pixel_generator_macros.svh"

module scrolling_tilemap_pixel_generator (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  stpg_pkg::req_type                     req_data,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output stpg_pkg::rsp_type                     rsp_data,

   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [stpg_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [stpg_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   // ---------------------------------------------------------------- config
   logic [15:0] page_select_ff;
   logic [9:0]  scroll_x_ff;
   logic [8:0]  scroll_y_ff;
   logic        opaque_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_select_ff <= '0;
         scroll_x_ff    <= '0;
         scroll_y_ff    <= '0;
         opaque_ff      <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            stpg_pkg::CSR_PAGE_SELECT: page_select_ff <= csr_wdata;
            stpg_pkg::CSR_SCROLL_X:    scroll_x_ff    <= csr_wdata[9:0];
            stpg_pkg::CSR_SCROLL_Y:    scroll_y_ff    <= csr_wdata[8:0];
            stpg_pkg::CSR_OPAQUE_MODE: opaque_ff      <= csr_wdata[0];
            default: ;  // unknown index ignored
         endcase
      end
   end

   // ---------------------------------------------------------- stage valids
   logic s1_v_ff, s2_v_ff, s3_v_ff, rsp_valid_ff;
   logic adv0, adv1, adv2, adv3;

   // A stage moves on when the one ahead is empty or moving
   assign adv3 = !rsp_valid_ff || !rsp_stall;
   assign adv2 = !s3_v_ff || adv3;
   assign adv1 = !s2_v_ff || adv2;
   assign adv0 = !s1_v_ff || adv1;

   assign req_stall = !adv0;
   wire   req_take  = req_valid && adv0;

   // ------------------------------------------- stage 0: scroll, page, tile
   logic [9:0]  vx;
   logic [8:0]  vy;
   logic [3:0]  page;
   logic        in_screen;
   logic        s0_render;
   logic [stpg_pkg::TILE_AW-1:0] tile_addr;
   logic        tile_we;
   logic [stpg_pkg::TILE_WIDTH-1:0] tile_word;

   always_comb begin
      vx        = 10'(req_data.screen_x) + scroll_x_ff;
      vy        = 9'(req_data.screen_y) + scroll_y_ff;
      page      = page_select_ff[{vy[8], vx[9], 2'b00} +: 4];
      in_screen = (32'(req_data.screen_x) < stpg_pkg::SCREEN_WIDTH)
               && (32'(req_data.screen_y) < stpg_pkg::SCREEN_HEIGHT);
      s0_render = (req_data.command == stpg_pkg::CMD_RENDER) && in_screen;
      tile_we   = req_take && (req_data.command == stpg_pkg::CMD_TILE)
               && (32'(req_data.address) < stpg_pkg::TILE_DEPTH);
      if (req_data.command == stpg_pkg::CMD_RENDER) begin
         tile_addr = stpg_pkg::TILE_AW'({page, vy[7:3], vx[8:3]});
      end else begin
         tile_addr = stpg_pkg::TILE_AW'(req_data.address);
      end
   end

   stpg_ram #(
      .WIDTH (stpg_pkg::TILE_WIDTH),
      .DEPTH (stpg_pkg::TILE_DEPTH)
   ) u_tile_ram (
      .clock   (clock),
      .wr_en   (tile_we),
      .rd_en   (adv0),
      .addr    (tile_addr),
      .wr_data (req_data.write_data[stpg_pkg::TILE_WIDTH-1:0]),
      .rd_data (tile_word)
   );

   logic                  s1_render_ff;
   stpg_pkg::cmd_type     s1_cmd_ff;
   logic [15:0]           s1_addr_ff;
   logic [23:0]           s1_wdata_ff;
   logic [2:0]            s1_px_ff;
   logic [2:0]            s1_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv0) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv0) begin
         s1_render_ff <= s0_render;
         s1_cmd_ff    <= req_data.command;
         s1_addr_ff   <= req_data.address;
         s1_wdata_ff  <= req_data.write_data;
         s1_px_ff     <= vx[2:0];
         s1_py_ff     <= vy[2:0];
      end
   end

   // ------------------------------------------------ stage 1: pattern read
   logic [12:0] code;
   logic [6:0]  color;
   logic        code_ok;
   logic [stpg_pkg::PAT_AW-1:0] pat_addr;
   logic        pat_we;
   logic [stpg_pkg::PAT_WIDTH-1:0] pat_row;

   always_comb begin
      code    = tile_word[12:0];
      color   = tile_word[12:6];   // overlaps the code field
      code_ok = 32'(code) < stpg_pkg::TILE_COUNT;
      pat_we  = adv1 && s1_v_ff && (s1_cmd_ff == stpg_pkg::CMD_PATTERN)
             && (32'(s1_addr_ff) < stpg_pkg::PATTERN_DEPTH);
      if (s1_cmd_ff == stpg_pkg::CMD_RENDER) begin
         pat_addr = stpg_pkg::PAT_AW'({code, s1_py_ff});
      end else begin
         pat_addr = stpg_pkg::PAT_AW'(s1_addr_ff);
      end
   end

   stpg_ram #(
      .WIDTH (stpg_pkg::PAT_WIDTH),
      .DEPTH (stpg_pkg::PATTERN_DEPTH)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (pat_we),
      .rd_en   (adv1),
      .addr    (pat_addr),
      .wr_data (s1_wdata_ff),
      .rd_data (pat_row)
   );

   logic                  s2_render_ff;
   stpg_pkg::cmd_type     s2_cmd_ff;
   logic [15:0]           s2_addr_ff;
   logic [15:0]           s2_wdata_ff;
   logic [2:0]            s2_px_ff;
   logic [6:0]            s2_color_ff;
   logic                  s2_code_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv1) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s2_render_ff  <= s1_render_ff;
         s2_cmd_ff     <= s1_cmd_ff;
         s2_addr_ff    <= s1_addr_ff;
         s2_wdata_ff   <= s1_wdata_ff[15:0];
         s2_px_ff      <= s1_px_ff;
         s2_color_ff   <= color;
         s2_code_ok_ff <= code_ok;
      end
   end

   // ---------------------------------------------- stage 2: pen, palette read
   logic [2:0] bit_idx;
   logic [2:0] pen;
   logic       transparent;
   logic [stpg_pkg::PAL_AW-1:0] pal_addr;
   logic       pal_we;
   logic [stpg_pkg::PAL_WIDTH-1:0] pal_word;

   always_comb begin
      bit_idx = ~s2_px_ff;   // leftmost pixel is bit 7 of each plane
      if (s2_code_ok_ff) begin
         pen = {pat_row[16 + 32'(bit_idx)], pat_row[8 + 32'(bit_idx)], pat_row[bit_idx]};
      end else begin
         pen = 3'd0;
      end
      transparent = (pen == 3'd0) && !opaque_ff;
      pal_we = adv2 && s2_v_ff && (s2_cmd_ff == stpg_pkg::CMD_PALETTE)
            && (32'(s2_addr_ff) < stpg_pkg::PALETTE_ENTRIES);
      if (s2_cmd_ff == stpg_pkg::CMD_RENDER) begin
         pal_addr = stpg_pkg::PAL_AW'({s2_color_ff, pen});
      end else begin
         pal_addr = stpg_pkg::PAL_AW'(s2_addr_ff);
      end
   end

   stpg_ram #(
      .WIDTH (stpg_pkg::PAL_WIDTH),
      .DEPTH (stpg_pkg::PALETTE_ENTRIES)
   ) u_palette_ram (
      .clock   (clock),
      .wr_en   (pal_we),
      .rd_en   (adv2),
      .addr    (pal_addr),
      .wr_data (s2_wdata_ff),
      .rd_data (pal_word)
   );

   logic       s3_render_ff;
   logic [2:0] s3_pen_ff;
   logic       s3_transparent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv2) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s3_render_ff      <= s2_render_ff;
         s3_pen_ff         <= pen;
         s3_transparent_ff <= transparent;
      end
   end

   // --------------------------------------- stage 3: color expand, output reg
   // Packed word: low nibbles R[3:0] G[7:4] B[11:8], LSBs in 14:12 (R 12, G 13, B 14)
   logic [4:0]        r5, g5, b5;
   stpg_pkg::rsp_type rsp_in;
   stpg_pkg::rsp_type rsp_ff;

   always_comb begin
      r5 = {pal_word[3:0],  pal_word[12]};
      g5 = {pal_word[7:4],  pal_word[13]};
      b5 = {pal_word[11:8], pal_word[14]};
      if (s3_transparent_ff) begin
         rsp_in = '0;
      end else begin
         rsp_in.drawn = 1'b1;
         rsp_in.pen   = s3_pen_ff;
         rsp_in.red   = stpg_pkg::expand5(r5);
         rsp_in.green = stpg_pkg::expand5(g5);
         rsp_in.blue  = stpg_pkg::expand5(b5);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv3) begin
         rsp_valid_ff <= s3_v_ff && s3_render_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------- checks
   `STPG_ASSERT_SAME(a_stall_only_when_full, clock, reset, req_stall, s1_v_ff && s2_v_ff && s3_v_ff && rsp_valid_ff && rsp_stall, "request stalled with room in the pipe")
   `STPG_ASSERT_SAME(a_transparent_needs_clear_opaque, clock, reset, rsp_valid && !rsp_data.drawn, !opaque_ff && rsp_data.pen == 3'd0 && rsp_data.red == 8'd0 && rsp_data.green == 8'd0 && rsp_data.blue == 8'd0, "bad transparent pixel")
   `STPG_ASSERT_NEXT(a_render_reaches_output, clock, reset, s3_v_ff && s3_render_ff && adv3, rsp_valid, "render lost before output")

endmodule

// File: hw/rtl/stpg_ram.sv
// Generic single-port RAM with registered read data.
module stpg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the scrolling tilemap pixel generator.
module tb_top;
   import stpg_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;  // far above the slowest legal run
   localparam int DRAIN_CYCLES = 12;      // pipe is four stages deep
   localparam int HOLD_CYCLES  = 150;     // one long receiver hold-off
   localparam int PHASE_ITEMS  = 230;
   localparam int MAX_PRINTS   = 50;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_WIDTH-1:0]  csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   // Register shadows, reset values of the block.
   logic [15:0] page_sel_reg = 16'h0000;
   logic [9:0]  scroll_x_reg = '0;
   logic [8:0]  scroll_y_reg = '0;
   logic        opaque_reg   = 1'b1;

   // Store contents as seen by requests already taken by the block.
   logic [15:0] tile_mem [0:TILE_DEPTH-1];
   logic [23:0] pat_mem  [0:PATTERN_DEPTH-1];
   logic [15:0] pal_mem  [0:PALETTE_ENTRIES-1];

   // Store contents as seen by the stimulus planner, which runs ahead of the
   // block. The written flags keep renders away from never-written entries.
   logic [15:0] plan_tile [0:TILE_DEPTH-1];
   logic [23:0] plan_pat  [0:PATTERN_DEPTH-1];
   bit          tile_ok   [0:TILE_DEPTH-1];
   bit          pat_ok    [0:PATTERN_DEPTH-1];
   bit          pal_ok    [0:PALETTE_ENTRIES-1];

   req_type     pending_requests[$];
   rsp_type     expected_pixels[$];

   logic [12:0] code_pool [0:31];
   int          err_count     = 0;
   int          cycle_count   = 0;
   int          item_count    = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          send_gap      = 0;
   int          recv_gap      = 0;
   int          win_x         = 0;
   int          win_y         = 0;
   bit          pressure_on   = 1'b0;
   int          hold_count    = 0;
   logic        holding;

   assign holding = pressure_on && (hold_count < HOLD_CYCLES);

   scrolling_tilemap_pixel_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Pixel arithmetic shared by the planner and the predictor
   // ---------------------------------------------------------------------

   // Virtual plane is 1024 x 512; the sums wrap at those sizes.
   function automatic logic [9:0] virt_x(input logic [8:0] sx);
      return 10'(sx) + scroll_x_reg;
   endfunction

   function automatic logic [8:0] virt_y(input logic [7:0] sy);
      return 9'(sy) + scroll_y_reg;
   endfunction

   // Quadrant picks the page nibble; a page is 32 rows of 64 tile words.
   function automatic logic [14:0] tile_addr(input logic [9:0] vx, input logic [8:0] vy);
      logic [3:0] page;
      page = page_sel_reg[{vy[8], vx[9], 2'b00} +: 4];
      return {page, vy[7:3], vx[8:3]};
   endfunction

   // Leftmost pixel sits in bit 7 of each plane byte.
   function automatic logic [2:0] pen_at(input logic [23:0] row, input logic [9:0] vx);
      int b;
      b = 7 - int'(vx[2:0]);
      return {row[16 + b], row[8 + b], row[b]};
   endfunction

   function automatic logic [7:0] widen5(input logic [4:0] v);
      int unsigned t;
      t = (int'(v) * 255 + 15) / 31;
      return t[7:0];
   endfunction

   // Expected pixel of a render request; returns 0 when nothing comes out.
   function automatic bit predict_pixel(input req_type r, output rsp_type px);
      logic [9:0]  vx;
      logic [8:0]  vy;
      logic [15:0] tw;
      logic [15:0] pw;
      logic [2:0]  pen;
      logic [4:0]  r5, g5, b5;
      px = '0;
      if (r.screen_x >= SCREEN_WIDTH || r.screen_y >= SCREEN_HEIGHT) return 1'b0;
      vx = virt_x(r.screen_x);
      vy = virt_y(r.screen_y);
      tw = tile_mem[tile_addr(vx, vy)];
      // colour is tw[12:6] and code tw[12:0]: the two fields overlap
      if (tw[12:0] < TILE_COUNT) pen = pen_at(pat_mem[{tw[12:0], vy[2:0]}], vx);
      else pen = 3'd0;
      if (pen == 3'd0 && !opaque_reg) return 1'b1;   // transparent: all zero
      pw = pal_mem[{tw[12:6], pen}];
      // each channel: four high bits from the low field, LSB from bits 14:12
      r5 = {pw[3:0], pw[12]};
      g5 = {pw[7:4], pw[13]};
      b5 = {pw[11:8], pw[14]};
      px.drawn = 1'b1;
      px.pen   = pen;
      px.red   = widen5(r5);
      px.green = widen5(g5);
      px.blue  = widen5(b5);
      return 1'b1;
   endfunction

   // Called once per request taken by the block, in order.
   task automatic take_request(input req_type r);
      rsp_type px;
      case (r.command)
         CMD_TILE: begin
            if (r.address < TILE_DEPTH) tile_mem[r.address[14:0]] = r.write_data[15:0];
         end
         CMD_PATTERN: begin
            if (r.address < PATTERN_DEPTH) pat_mem[r.address] = r.write_data;
         end
         CMD_PALETTE: begin
            if (r.address < PALETTE_ENTRIES) pal_mem[r.address[9:0]] = r.write_data[15:0];
         end
         CMD_RENDER: begin
            if (predict_pixel(r, px)) expected_pixels.push_back(px);
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      err_count++;
      if (err_count <= MAX_PRINTS) $display("cycle %0d: %s", cycle_count, what);
   endtask

   task automatic check_pixel(input rsp_type got);
      rsp_type want;
      if (expected_pixels.size() == 0) begin
         report_mismatch($sformatf("pixel %h with none outstanding", got));
      end else begin
         want = expected_pixels.pop_front();
         if (got.drawn !== want.drawn || got.pen !== want.pen || got.red !== want.red ||
             got.green !== want.green || got.blue !== want.blue) begin
            report_mismatch($sformatf(
               "drawn %b/%b pen %0d/%0d rgb %h_%h_%h/%h_%h_%h (got/exp)",
               got.drawn, want.drawn, got.pen, want.pen, got.red, got.green, got.blue,
               want.red, want.green, want.blue));
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus planning
   // ---------------------------------------------------------------------

   // Fields a command does not use get random junk.
   function automatic req_type make_item(input cmd_type c, input logic [8:0] sx,
                                         input logic [7:0] sy, input logic [15:0] a,
                                         input logic [23:0] d);
      req_type r;
      r.command    = c;
      r.screen_x   = sx;
      r.screen_y   = sy;
      r.address    = a;
      r.write_data = d;
      if (c == CMD_RENDER) begin
         r.address    = 16'($urandom);
         r.write_data = 24'($urandom);
      end else begin
         r.screen_x = 9'($urandom);
         r.screen_y = 8'($urandom);
      end
      return r;
   endfunction

   function automatic void queue_item(input req_type r);
      bit dropped;
      dropped = 1'b0;
      case (r.command)
         CMD_TILE: begin
            if (r.address < TILE_DEPTH) begin
               plan_tile[r.address[14:0]] = r.write_data[15:0];
               tile_ok[r.address[14:0]]   = 1'b1;
            end else dropped = 1'b1;
         end
         CMD_PATTERN: begin
            if (r.address < PATTERN_DEPTH) begin
               plan_pat[r.address] = r.write_data;
               pat_ok[r.address]   = 1'b1;
            end else dropped = 1'b1;
         end
         CMD_PALETTE: begin
            if (r.address < PALETTE_ENTRIES) pal_ok[r.address[9:0]] = 1'b1;
            else dropped = 1'b1;
         end
         CMD_RENDER: ;
      endcase
      if (!dropped) item_count++;
      pending_requests.push_back(r);
   endfunction

   // Mostly reuse a small set of codes so pattern rows get read many times.
   function automatic logic [12:0] pick_code();
      if ($urandom_range(0, 9) < 7) return code_pool[$urandom_range(0, 31)];
      return 13'($urandom);
   endfunction

   function automatic logic [23:0] pick_row();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 24'h000000;
      if (sel == 1) return 24'hffffff;
      return 24'($urandom);
   endfunction

   // Render request preceded by whatever writes make every read it causes
   // hit a written entry.
   function automatic void plan_render(input logic [8:0] sx, input logic [7:0] sy);
      logic [9:0]  vx;
      logic [8:0]  vy;
      logic [14:0] ta;
      logic [12:0] code;
      logic [15:0] pa;
      logic [2:0]  pen;
      logic [9:0]  la;
      if (sx < SCREEN_WIDTH && sy < SCREEN_HEIGHT) begin
         vx = virt_x(sx);
         vy = virt_y(sy);
         ta = tile_addr(vx, vy);
         if (!tile_ok[ta])
            queue_item(make_item(CMD_TILE, '0, '0, 16'(ta),
                                 {8'($urandom), 3'($urandom), pick_code()}));
         code = plan_tile[ta][12:0];
         pen  = 3'd0;
         if (code < TILE_COUNT) begin
            pa = {code, vy[2:0]};
            if (!pat_ok[pa]) queue_item(make_item(CMD_PATTERN, '0, '0, pa, pick_row()));
            pen = pen_at(plan_pat[pa], vx);
         end
         if (pen != 3'd0 || opaque_reg) begin
            la = {plan_tile[ta][12:6], pen};
            if (!pal_ok[la]) queue_item(make_item(CMD_PALETTE, '0, '0, 16'(la), 24'($urandom)));
         end
      end
      queue_item(make_item(CMD_RENDER, sx, sy, '0, '0));
   endfunction

   // Short directed opening at reset settings.
   function automatic void directed_items();
      // code 0, colour 0, empty row, black palette entry
      queue_item(make_item(CMD_TILE,    '0, '0, 16'd0, 24'hff0000));
      queue_item(make_item(CMD_PATTERN, '0, '0, 16'd0, 24'h000000));
      queue_item(make_item(CMD_PALETTE, '0, '0, 16'd0, 24'h000000));
      queue_item(make_item(CMD_RENDER,  9'd0, 8'd0, '0, '0));
      // top code and colour, full row, white last palette entry
      queue_item(make_item(CMD_TILE,    '0, '0, 16'd1, 24'h00ffff));
      queue_item(make_item(CMD_PATTERN, '0, '0, 16'd65528, 24'hffffff));
      queue_item(make_item(CMD_PALETTE, '0, '0, 16'd1023, 24'h00ffff));
      queue_item(make_item(CMD_RENDER,  9'd8, 8'd0, '0, '0));
      // out-of-range writes are dropped; the pattern store spans all addresses
      queue_item(make_item(CMD_TILE,    '0, '0, 16'hffff, 24'($urandom)));
      queue_item(make_item(CMD_PALETTE, '0, '0, 16'hffff, 24'($urandom)));
      queue_item(make_item(CMD_PATTERN, '0, '0, 16'hffff, 24'hffffff));
      queue_item(make_item(CMD_RENDER,  9'd15, 8'd7, '0, '0));
      // screen corners
      plan_render(9'd319, 8'd223);
      plan_render(9'd0, 8'd223);
      plan_render(9'd319, 8'd0);
      // off screen: no pixel
      queue_item(make_item(CMD_RENDER, 9'd320, 8'd0, '0, '0));
      queue_item(make_item(CMD_RENDER, 9'd0, 8'd224, '0, '0));
      queue_item(make_item(CMD_RENDER, 9'd511, 8'd255, '0, '0));
   endfunction

   function automatic void random_burst(input int n);
      int          target;
      int          sel;
      logic [15:0] a;
      target = item_count + n;
      while (item_count < target) begin
         sel = $urandom_range(0, 99);
         if (sel < 60)
            plan_render(9'(win_x + $urandom_range(0, 23)), 8'(win_y + $urandom_range(0, 15)));
         else if (sel < 80)
            plan_render(9'($urandom_range(0, SCREEN_WIDTH - 1)),
                        8'($urandom_range(0, SCREEN_HEIGHT - 1)));
         else if (sel < 86)
            plan_render(9'($urandom), 8'($urandom));
         else if (sel < 91)
            queue_item(make_item(CMD_TILE, '0, '0, 16'($urandom),
                                 {8'($urandom), 3'($urandom), pick_code()}));
         else if (sel < 95)
            queue_item(make_item(CMD_PATTERN, '0, '0, 16'($urandom), pick_row()));
         else begin
            a = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                            : 16'($urandom_range(0, PALETTE_ENTRIES - 1));
            queue_item(make_item(CMD_PALETTE, '0, '0, a, 24'($urandom)));
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Register writes and phase sequencing
   // ---------------------------------------------------------------------

   task automatic write_csr(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] val);
      @(posedge clock);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_PAGE_SELECT: page_sel_reg = val;
         CSR_SCROLL_X:    scroll_x_reg = val[9:0];
         CSR_SCROLL_Y:    scroll_y_reg = val[8:0];
         CSR_OPAQUE_MODE: opaque_reg   = val[0];
         default: ;
      endcase
   endtask

   // Every request taken and every pixel back, then let writes and
   // off-screen renders leave the pipe.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_pixels.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input logic [15:0] page, input logic [15:0] sx,
                            input logic [15:0] sy, input logic [15:0] op,
                            input int send_pct, input int recv_pct, input bit pressure);
      wait_idle();
      write_csr(CSR_PAGE_SELECT, page);
      write_csr(CSR_SCROLL_X, sx);
      write_csr(CSR_SCROLL_Y, sy);
      write_csr(CSR_OPAQUE_MODE, op);
      // index past the register list; must leave all four alone
      write_csr(8'(CSR_OPAQUE_MODE + $urandom_range(1, 252)), 16'($urandom));
      @(negedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      if (pressure) pressure_on = 1'b1;
      win_x = $urandom_range(0, SCREEN_WIDTH - 24);
      win_y = $urandom_range(0, SCREEN_HEIGHT - 16);
      random_burst(PHASE_ITEMS);
   endtask

   initial begin
      int k;
      for (k = 0; k < 32; k++) code_pool[k] = 13'($urandom);
      code_pool[0] = '0;
      code_pool[1] = '1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 20;
      recv_idle_pct = 4;
      directed_items();
      // register extremes; scroll values carry junk above their widths
      run_phase(16'hffff, 16'hffff, 16'hffff, 16'h0000, 25, 8, 1'b0);
      run_phase(16'h0000, 16'h0000, 16'h0000, 16'h0001, 0, 0, 1'b0);
      run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 35, 12, 1'b0);
      // receiver holds off while the sender keeps offering
      run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 0, 3, 1'b1);
      repeat (3)
         run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   $urandom_range(5, 40), $urandom_range(2, 12), 1'b0);
      // closing stretch runs flat out on both sides
      run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 0, 0, 1'b0);
      wait_idle();
      if (err_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request driver: holds a stalled request steady, inserts idle bursts
   // only between requests.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) take_request(req_data);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               req_data  <= pending_requests.pop_front();
               req_valid <= 1'b1;
               if ($urandom_range(0, 99) < send_idle_pct) send_gap = $urandom_range(1, 19);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor and receiver stall
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_pixel(rsp_data);
         if (recv_gap == 0 && $urandom_range(0, 99) < recv_idle_pct)
            recv_gap = $urandom_range(1, 19);
         rsp_stall <= holding || recv_gap > 0;
         if (recv_gap > 0) recv_gap--;
      end
   end

   // Long hold-off counter; runs once the pressure phase starts.
   always @(posedge clock) begin
      if (holding) hold_count <= hold_count + 1;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule
